// ----- rtl/core/tw_pkg.sv -----
// Shared constants, types and multiply helpers for the Tweedie gradient pipeline.
`default_nettype none

package tw_pkg;

    localparam int TAYLOR_TERMS = 25;
    localparam int STEP_STAGES  = 5;
    localparam int EXP_LAT      = 5 + STEP_STAGES * TAYLOR_TERMS + 1;
    localparam int K_W          = 13;
    localparam int E_W          = 14;

    localparam logic [63:0] LOG2E_Q63 = 64'hB8AA_3B29_5C17_F0BC;
    localparam logic [63:0] LN2_Q64   = 64'hB172_17F7_D1CF_79AC;
    localparam logic [63:0] ONE_Q62   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] SAT_POS   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG   = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } pp_t;

    typedef struct packed {
        logic [31:0] y;
        logic [5:0]  bl;
        logic        last;
    } side_t;

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return {32'd0, a} * {32'd0, b};
    endfunction

    function automatic pp_t pp64(input logic [63:0] a, input logic [63:0] b);
        pp_t p;
        p.ll = mul32(a[31:0], b[31:0]);
        p.lh = mul32(a[31:0], b[63:32]);
        p.hl = mul32(a[63:32], b[31:0]);
        p.hh = mul32(a[63:32], b[63:32]);
        return p;
    endfunction

    function automatic logic [127:0] pp_sum(input pp_t p);
        return {64'd0, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0} + {p.hh, 64'd0};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tw_exp.sv -----
// Pipelined exp(+-mag * 2^-54) as a Q1.62 mantissa and a power-of-two exponent.
`default_nettype none

module tw_exp
    import tw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [63:0]           mag,
    input  wire logic                  neg,
    output logic signed [K_W-1:0]      k,
    output logic [63:0]                m
);

    pp_t                   e1_pp_reg;
    logic                  e1_neg_reg;
    logic [63:0]           e2_hi_reg;
    logic                  e2_neg_reg;
    logic [52:0]           e3_fp_reg;
    logic signed [K_W-1:0] e3_k_reg;
    pp_t                   e4_pp_reg;
    logic signed [K_W-1:0] e4_k_reg;
    logic [61:0]           e5_g_reg;
    logic signed [K_W-1:0] e5_k_reg;

    logic [127:0]          e2_prod;
    logic [127:0]          e5_prod;
    logic [11:0]           ip_next;
    logic [52:0]           fp_next;
    logic signed [K_W-1:0] k_next;

    logic [63:0]           t_chain [0:TAYLOR_TERMS];
    logic [63:0]           s_chain [0:TAYLOR_TERMS];
    logic [61:0]           g_chain [0:TAYLOR_TERMS];
    logic signed [K_W-1:0] k_chain [0:TAYLOR_TERMS];

    logic [63:0]           m_reg;
    logic signed [K_W-1:0] k_reg;

    assign e2_prod = pp_sum(e1_pp_reg);
    assign e5_prod = pp_sum(e4_pp_reg);

    always_comb
    begin
        ip_next = {1'b0, e2_hi_reg[63:53]};
        fp_next = e2_hi_reg[52:0];
        if (e2_neg_reg && (fp_next != '0))
        begin
            ip_next = ip_next + 12'd1;
            fp_next = (~fp_next) + 53'd1;
        end
        k_next = e2_neg_reg ? K_W'(-$signed({1'b0, ip_next})) : K_W'($signed({1'b0, ip_next}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_pp_reg  <= pp64(mag, LOG2E_Q63);
            e1_neg_reg <= neg;
            e2_hi_reg  <= e2_prod[127:64];
            e2_neg_reg <= e1_neg_reg;
            e3_fp_reg  <= fp_next;
            e3_k_reg   <= k_next;
            e4_pp_reg  <= pp64({e3_fp_reg, 11'd0}, LN2_Q64);
            e4_k_reg   <= e3_k_reg;
            e5_g_reg   <= e5_prod[127:66];
            e5_k_reg   <= e4_k_reg;
        end
    end

    assign t_chain[0] = ONE_Q62;
    assign s_chain[0] = '0;
    assign g_chain[0] = e5_g_reg;
    assign k_chain[0] = e5_k_reg;

    for (genvar n = 1; n <= TAYLOR_TERMS; n++)
    begin : g_term
        localparam logic [63:0] DIVN  = 64'(n);
        localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / 64'(n);

        pp_t                   a_pp_reg;
        logic [63:0]           a_s_reg;
        logic [61:0]           a_g_reg;
        logic signed [K_W-1:0] a_k_reg;
        logic [63:0]           b_x_reg;
        logic [63:0]           b_s_reg;
        logic [61:0]           b_g_reg;
        logic signed [K_W-1:0] b_k_reg;
        pp_t                   c_pp_reg;
        logic [63:0]           c_x_reg;
        logic [63:0]           c_s_reg;
        logic [61:0]           c_g_reg;
        logic signed [K_W-1:0] c_k_reg;
        logic [63:0]           d_q0_reg;
        logic [63:0]           d_x_reg;
        logic [63:0]           d_s_reg;
        logic [61:0]           d_g_reg;
        logic signed [K_W-1:0] d_k_reg;
        logic [63:0]           e_t_reg;
        logic [63:0]           e_s_reg;
        logic [61:0]           e_g_reg;
        logic signed [K_W-1:0] e_k_reg;

        logic [127:0]          b_prod;
        logic [127:0]          d_prod;
        logic [63:0]           rem_next;
        logic [63:0]           q_next;

        assign b_prod   = pp_sum(a_pp_reg);
        assign d_prod   = pp_sum(c_pp_reg);
        assign rem_next = d_x_reg - 64'(d_q0_reg * DIVN);
        assign q_next   = (rem_next >= DIVN) ? d_q0_reg + 64'd1 : d_q0_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_pp_reg <= pp64(t_chain[n-1], {2'b00, g_chain[n-1]});
                a_s_reg  <= s_chain[n-1] + t_chain[n-1];
                a_g_reg  <= g_chain[n-1];
                a_k_reg  <= k_chain[n-1];
                b_x_reg  <= b_prod[125:62];
                b_s_reg  <= a_s_reg;
                b_g_reg  <= a_g_reg;
                b_k_reg  <= a_k_reg;
                c_pp_reg <= pp64(b_x_reg, RECIP);
                c_x_reg  <= b_x_reg;
                c_s_reg  <= b_s_reg;
                c_g_reg  <= b_g_reg;
                c_k_reg  <= b_k_reg;
                d_q0_reg <= d_prod[127:64];
                d_x_reg  <= c_x_reg;
                d_s_reg  <= c_s_reg;
                d_g_reg  <= c_g_reg;
                d_k_reg  <= c_k_reg;
                e_t_reg  <= q_next;
                e_s_reg  <= d_s_reg;
                e_g_reg  <= d_g_reg;
                e_k_reg  <= d_k_reg;
            end
        end

        assign t_chain[n] = e_t_reg;
        assign s_chain[n] = e_s_reg;
        assign g_chain[n] = e_g_reg;
        assign k_chain[n] = e_k_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= s_chain[TAYLOR_TERMS] + t_chain[TAYLOR_TERMS];
            k_reg <= k_chain[TAYLOR_TERMS];
        end
    end

    assign m = m_reg;
    assign k = k_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tweedie_gradient.sv -----
// Top level of the Tweedie loss gradient pipeline.
//
// Channel  Handshake             Words
// input    in_valid / in_stall   response, prediction, offset, last
// result   out_valid / out_stall gradient, saturated, last_out
// config   cfg_we                cfg_wdata (power, Q2.30)
//
// One word enters per cycle while in_stall is low.
// Each exponential uses the 25-term series: five stages per term, each term with a
// 64-bit product and a reciprocal divide cut into 32-bit partial products.
// Reset clears all valid bits and sets power to 1.5.
// A two-word output buffer holds results under stall; in_stall is its full flag.
`default_nettype none

module tweedie_gradient
    import tw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [31:0]        response,
    input  wire logic signed [31:0] prediction,
    input  wire logic signed [31:0] offset,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [63:0]      gradient,
    output logic                    saturated,
    output logic                    last_out
);

    function automatic logic [5:0] bit_len(input logic [31:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

    logic        en;
    logic [31:0] power_reg;

    // front stages
    logic               f1_v_reg;
    logic [31:0]        f1_y_reg;
    logic signed [32:0] f1_s_reg;
    logic               f1_last_reg;

    logic               f2_v_reg;
    side_t              f2_side_reg;
    logic [32:0]        f2_sabs_reg;
    logic               f2_sneg_reg;
    logic [31:0]        f2_c1abs_reg;
    logic               f2_c1neg_reg;
    logic [31:0]        f2_c2abs_reg;
    logic               f2_c2neg_reg;

    logic               f3_v_reg;
    side_t              f3_side_reg;
    logic [63:0]        f3_mag1_reg;
    logic               f3_neg1_reg;
    logic [63:0]        f3_mag2_reg;
    logic               f3_neg2_reg;

    logic signed [32:0] c1_next;
    logic signed [32:0] c2_next;
    logic [63:0]        mag1_next;
    logic [63:0]        mag2_next;

    logic               v_dly_reg    [0:EXP_LAT-1];
    side_t              side_dly_reg [0:EXP_LAT-1];

    logic signed [K_W-1:0] k1;
    logic signed [K_W-1:0] k2;
    logic [63:0]           m1;
    logic [63:0]           m2;

    // combine stages
    logic                  x1_v_reg;
    logic [63:0]           x1_pl_reg;
    logic [63:0]           x1_ph_reg;
    logic signed [K_W-1:0] x1_k1_reg;
    logic [62:0]           x1_ma_reg;
    logic signed [E_W-1:0] x1_ea_reg;
    logic [5:0]            x1_bl_reg;
    logic                  x1_last_reg;

    logic                  x2_v_reg;
    logic [94:0]           x2_p_reg;
    logic signed [K_W-1:0] x2_k1_reg;
    logic [62:0]           x2_ma_reg;
    logic signed [E_W-1:0] x2_ea_reg;
    logic [5:0]            x2_bl_reg;
    logic                  x2_last_reg;

    logic                  x3_v_reg;
    logic [94:0]           x3_p_reg;
    logic [5:0]            x3_sh_reg;
    logic signed [E_W-1:0] x3_eb_reg;
    logic                  x3_bnz_reg;
    logic [62:0]           x3_ma_reg;
    logic signed [E_W-1:0] x3_ea_reg;
    logic                  x3_last_reg;

    logic                  x4_v_reg;
    logic [62:0]           x4_mb_reg;
    logic signed [E_W-1:0] x4_eb_reg;
    logic                  x4_bnz_reg;
    logic [62:0]           x4_ma_reg;
    logic signed [E_W-1:0] x4_ea_reg;
    logic                  x4_last_reg;

    logic                  x5_v_reg;
    logic [62:0]           x5_ma_reg;
    logic [62:0]           x5_mb_reg;
    logic signed [E_W-1:0] x5_da_reg;
    logic signed [E_W-1:0] x5_db_reg;
    logic signed [E_W-1:0] x5_emax_reg;
    logic                  x5_bnz_reg;
    logic                  x5_last_reg;

    logic                  x6_v_reg;
    logic [62:0]           x6_a_reg;
    logic [62:0]           x6_b_reg;
    logic signed [E_W-1:0] x6_emax_reg;
    logic                  x6_last_reg;

    logic                  x7_v_reg;
    logic [63:0]           x7_d_reg;
    logic signed [E_W-1:0] x7_emax_reg;
    logic                  x7_last_reg;

    logic                  x8_v_reg;
    logic [63:0]           x8_mag_reg;
    logic                  x8_neg_reg;
    logic signed [E_W-1:0] x8_sh2_reg;
    logic                  x8_last_reg;

    logic                  x9_v_reg;
    logic [63:0]           x9_mag_reg;
    logic                  x9_neg_reg;
    logic                  x9_sat_reg;
    logic                  x9_last_reg;

    logic                  x10_v_reg;
    logic [63:0]           x10_grad_reg;
    logic                  x10_sat_reg;
    logic                  x10_last_reg;

    logic [94:0]           p_next;
    logic [6:0]            top_idx;
    logic [5:0]            sh_next;
    logic signed [E_W-1:0] eb_next;
    logic [94:0]           pshift;
    logic signed [E_W-1:0] emax_next;
    logic [63:0]           mag_next;
    logic [63:0]           lim_next;
    logic signed [E_W-1:0] nsh_next;
    logic                  sat_next;

    // output buffer
    logic        ob_v_reg;
    logic [63:0] ob_grad_reg;
    logic        ob_sat_reg;
    logic        ob_last_reg;
    logic        sk_v_reg;
    logic [63:0] sk_grad_reg;
    logic        sk_sat_reg;
    logic        sk_last_reg;
    logic        take;
    logic        ob_from_pipe;
    logic        sk_from_pipe;
    logic        ob_from_sk;

    assign en       = !sk_v_reg;
    assign in_stall = sk_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg <= 32'h6000_0000;
        end
        else if (cfg_we)
        begin
            power_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        c1_next   = 33'sh0_4000_0000 - $signed({1'b0, power_reg});
        c2_next   = 33'sh0_8000_0000 - $signed({1'b0, power_reg});
        mag1_next = 64'({33'd0, f2_c1abs_reg} * {32'd0, f2_sabs_reg});
        mag2_next = 64'({33'd0, f2_c2abs_reg} * {32'd0, f2_sabs_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_y_reg     <= response;
            f1_s_reg     <= {prediction[31], prediction} + {offset[31], offset};
            f1_last_reg  <= last;

            f2_side_reg  <= '{y: f1_y_reg, bl: bit_len(f1_y_reg), last: f1_last_reg};
            f2_sabs_reg  <= f1_s_reg[32] ? 33'(-f1_s_reg) : f1_s_reg;
            f2_sneg_reg  <= f1_s_reg[32];
            f2_c1abs_reg <= c1_next[32] ? 32'(-c1_next) : c1_next[31:0];
            f2_c1neg_reg <= c1_next[32];
            f2_c2abs_reg <= c2_next[32] ? 32'(-c2_next) : c2_next[31:0];
            f2_c2neg_reg <= c2_next[32];

            f3_side_reg  <= f2_side_reg;
            f3_mag1_reg  <= mag1_next;
            f3_neg1_reg  <= f2_c1neg_reg ^ f2_sneg_reg;
            f3_mag2_reg  <= mag2_next;
            f3_neg2_reg  <= f2_c2neg_reg ^ f2_sneg_reg;

            side_dly_reg[0] <= f3_side_reg;
            for (int i = 1; i < EXP_LAT; i++)
            begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
        end
    end

    tw_exp u_exp1 (
        .clk (clk),
        .en  (en),
        .mag (f3_mag1_reg),
        .neg (f3_neg1_reg),
        .k   (k1),
        .m   (m1)
    );

    tw_exp u_exp2 (
        .clk (clk),
        .en  (en),
        .mag (f3_mag2_reg),
        .neg (f3_neg2_reg),
        .k   (k2),
        .m   (m2)
    );

    always_comb
    begin
        p_next   = {x1_ph_reg[62:0], 32'd0} + {31'd0, x1_pl_reg};
        top_idx  = 7'(x2_bl_reg) + 7'd62;
        if (x2_bl_reg == '0)
        begin
            sh_next = '0;
        end
        else if (x2_p_reg[top_idx])
        begin
            sh_next = x2_bl_reg;
        end
        else
        begin
            sh_next = x2_bl_reg - 6'd1;
        end
        eb_next   = E_W'(x2_k1_reg) - E_W'(78) + E_W'({1'b0, sh_next});
        pshift    = x3_p_reg >> x3_sh_reg;
        emax_next = (x4_bnz_reg && (x4_eb_reg > x4_ea_reg)) ? x4_eb_reg : x4_ea_reg;
    end

    always_comb
    begin
        lim_next = x8_neg_reg ? SAT_NEG : SAT_POS;
        nsh_next = -x8_sh2_reg;
        sat_next = 1'b0;
        mag_next = x8_mag_reg;
        if (x8_mag_reg != '0)
        begin
            if (!x8_sh2_reg[E_W-1])
            begin
                if ((x8_sh2_reg >= E_W'(64)) || (x8_mag_reg > (lim_next >> x8_sh2_reg[5:0])))
                begin
                    sat_next = 1'b1;
                    mag_next = lim_next;
                end
                else
                begin
                    mag_next = x8_mag_reg << x8_sh2_reg[5:0];
                end
            end
            else if (nsh_next >= E_W'(64))
            begin
                mag_next = '0;
            end
            else
            begin
                mag_next = x8_mag_reg >> nsh_next[5:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_pl_reg   <= mul32(side_dly_reg[EXP_LAT-1].y, m1[31:0]);
            x1_ph_reg   <= mul32(side_dly_reg[EXP_LAT-1].y, {1'b0, m1[62:32]});
            x1_k1_reg   <= k1;
            x1_ma_reg   <= m2[62:0];
            x1_ea_reg   <= E_W'(k2) - E_W'(62);
            x1_bl_reg   <= side_dly_reg[EXP_LAT-1].bl;
            x1_last_reg <= side_dly_reg[EXP_LAT-1].last;

            x2_p_reg    <= p_next;
            x2_k1_reg   <= x1_k1_reg;
            x2_ma_reg   <= x1_ma_reg;
            x2_ea_reg   <= x1_ea_reg;
            x2_bl_reg   <= x1_bl_reg;
            x2_last_reg <= x1_last_reg;

            x3_p_reg    <= x2_p_reg;
            x3_sh_reg   <= sh_next;
            x3_eb_reg   <= eb_next;
            x3_bnz_reg  <= (x2_bl_reg != '0);
            x3_ma_reg   <= x2_ma_reg;
            x3_ea_reg   <= x2_ea_reg;
            x3_last_reg <= x2_last_reg;

            x4_mb_reg   <= pshift[62:0];
            x4_eb_reg   <= x3_eb_reg;
            x4_bnz_reg  <= x3_bnz_reg;
            x4_ma_reg   <= x3_ma_reg;
            x4_ea_reg   <= x3_ea_reg;
            x4_last_reg <= x3_last_reg;

            x5_ma_reg   <= x4_ma_reg;
            x5_mb_reg   <= x4_mb_reg;
            x5_da_reg   <= emax_next - x4_ea_reg;
            x5_db_reg   <= emax_next - x4_eb_reg;
            x5_emax_reg <= emax_next;
            x5_bnz_reg  <= x4_bnz_reg;
            x5_last_reg <= x4_last_reg;

            x6_a_reg    <= (x5_da_reg >= E_W'(64)) ? '0 : x5_ma_reg >> x5_da_reg[5:0];
            x6_b_reg    <= (!x5_bnz_reg || (x5_db_reg >= E_W'(64))) ? '0
                                                                     : x5_mb_reg >> x5_db_reg[5:0];
            x6_emax_reg <= x5_emax_reg;
            x6_last_reg <= x5_last_reg;

            x7_d_reg    <= {1'b0, x6_a_reg} - {1'b0, x6_b_reg};
            x7_emax_reg <= x6_emax_reg;
            x7_last_reg <= x6_last_reg;

            x8_mag_reg  <= x7_d_reg[63] ? (~x7_d_reg) + 64'd1 : x7_d_reg;
            x8_neg_reg  <= x7_d_reg[63];
            x8_sh2_reg  <= x7_emax_reg + E_W'(32);
            x8_last_reg <= x7_last_reg;

            x9_mag_reg  <= mag_next;
            x9_neg_reg  <= x8_neg_reg;
            x9_sat_reg  <= sat_next;
            x9_last_reg <= x8_last_reg;

            x10_grad_reg <= x9_neg_reg ? (~x9_mag_reg) + 64'd1 : x9_mag_reg;
            x10_sat_reg  <= x9_sat_reg;
            x10_last_reg <= x9_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg  <= 1'b0;
            f2_v_reg  <= 1'b0;
            f3_v_reg  <= 1'b0;
            for (int i = 0; i < EXP_LAT; i++)
            begin
                v_dly_reg[i] <= 1'b0;
            end
            x1_v_reg  <= 1'b0;
            x2_v_reg  <= 1'b0;
            x3_v_reg  <= 1'b0;
            x4_v_reg  <= 1'b0;
            x5_v_reg  <= 1'b0;
            x6_v_reg  <= 1'b0;
            x7_v_reg  <= 1'b0;
            x8_v_reg  <= 1'b0;
            x9_v_reg  <= 1'b0;
            x10_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg     <= in_valid;
            f2_v_reg     <= f1_v_reg;
            f3_v_reg     <= f2_v_reg;
            v_dly_reg[0] <= f3_v_reg;
            for (int i = 1; i < EXP_LAT; i++)
            begin
                v_dly_reg[i] <= v_dly_reg[i-1];
            end
            x1_v_reg  <= v_dly_reg[EXP_LAT-1];
            x2_v_reg  <= x1_v_reg;
            x3_v_reg  <= x2_v_reg;
            x4_v_reg  <= x3_v_reg;
            x5_v_reg  <= x4_v_reg;
            x6_v_reg  <= x5_v_reg;
            x7_v_reg  <= x6_v_reg;
            x8_v_reg  <= x7_v_reg;
            x9_v_reg  <= x8_v_reg;
            x10_v_reg <= x9_v_reg;
        end
    end

    assign take         = ob_v_reg && !out_stall;
    assign sk_from_pipe = en && x10_v_reg && ob_v_reg && !take;
    assign ob_from_pipe = en && x10_v_reg && !(ob_v_reg && !take);
    assign ob_from_sk   = !en && take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_v_reg <= 1'b0;
            sk_v_reg <= 1'b0;
        end
        else if (ob_from_sk)
        begin
            sk_v_reg <= 1'b0;
        end
        else if (sk_from_pipe)
        begin
            sk_v_reg <= 1'b1;
        end
        else if (ob_from_pipe)
        begin
            ob_v_reg <= 1'b1;
        end
        else if (take)
        begin
            ob_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ob_from_sk)
        begin
            ob_grad_reg <= sk_grad_reg;
            ob_sat_reg  <= sk_sat_reg;
            ob_last_reg <= sk_last_reg;
        end
        else if (ob_from_pipe)
        begin
            ob_grad_reg <= x10_grad_reg;
            ob_sat_reg  <= x10_sat_reg;
            ob_last_reg <= x10_last_reg;
        end
        if (sk_from_pipe)
        begin
            sk_grad_reg <= x10_grad_reg;
            sk_sat_reg  <= x10_sat_reg;
            sk_last_reg <= x10_last_reg;
        end
    end

    assign out_valid = ob_v_reg;
    assign gradient  = ob_grad_reg;
    assign saturated = ob_sat_reg;
    assign last_out  = ob_last_reg;

endmodule

`default_nettype wire
